// ----- src/dqe_pkg.sv -----
// ----------------------------------------------------------------------------
// dqe_pkg
// Shared types, codes and the microcode table of the DNS query encoder.
// ----------------------------------------------------------------------------
package dqe_pkg;

	localparam int LABEL_MAX_DEF = 63;
	localparam logic [7:0] CHAR_DOT = 8'h2E;
	localparam int PC_W = 5;
	localparam int APB_AW = 4;

	typedef enum logic [1:0] {
		ACT_START   = 2'd0,
		ACT_CHAR    = 2'd1,
		ACT_END     = 2'd2,
		ACT_TRAILER = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_QUERY_ID   = 2'd0,
		REG_RECURSION  = 2'd1,
		REG_QUERY_TYPE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] name_char;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       label_overflow;
	} msg_t;

	// Source of the byte emitted by one microcode step.
	typedef enum logic [2:0] {
		SRC_ZERO,
		SRC_ONE,
		SRC_ID_HI,
		SRC_ID_LO,
		SRC_RD,
		SRC_QTYPE,
		SRC_COUNT,
		SRC_MEM
	} byte_src_t;

	// Sequencing after a step.
	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_DONE,
		JMP_IF_EMPTY,
		JMP_LOOP
	} jmp_t;

	typedef struct packed {
		byte_src_t src;
		logic      use_ovf;
		jmp_t      jmp;
	} ucode_t;

	// Control from the sequencer to the label buffer.
	typedef struct packed {
		logic wr;
		logic set_ovf;
		logic clear;
		logic rd;
	} lbuf_ctl_t;

	localparam logic [PC_W-1:0] PC_HEADER  = 5'd0;
	localparam logic [PC_W-1:0] PC_TRAILER = 5'd12;
	localparam logic [PC_W-1:0] PC_FLUSH   = 5'd17;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{src: SRC_ZERO, use_ovf: 1'b0, jmp: JMP_NEXT};
		case (pc)
			5'd0: w.src = SRC_ID_HI;
			5'd1: w.src = SRC_ID_LO;
			5'd2: w.src = SRC_RD;
			5'd5: w.src = SRC_ONE;
			5'd11: w.jmp = JMP_DONE;
			5'd14: w.src = SRC_QTYPE;
			5'd16: begin
				w.src = SRC_ONE;
				w.jmp = JMP_DONE;
			end
			5'd17: begin
				w.src     = SRC_COUNT;
				w.use_ovf = 1'b1;
				w.jmp     = JMP_IF_EMPTY;
			end
			5'd18: begin
				w.src     = SRC_MEM;
				w.use_ovf = 1'b1;
				w.jmp     = JMP_LOOP;
			end
			default: w.src = SRC_ZERO;
		endcase
		return w;
	endfunction

endpackage

// ----- src/dqe_label_buf.sv -----
// ----------------------------------------------------------------------------
// dqe_label_buf
// Pending label storage: character memory, fill count and overflow flag.
// ----------------------------------------------------------------------------
module dqe_label_buf
	import dqe_pkg::*;
#(
	parameter int LABEL_MAX = LABEL_MAX_DEF,
	localparam int CNT_W = $clog2(LABEL_MAX + 1),
	localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lbuf_ctl_t        ctl,
	input  logic [7:0]       wdata,
	input  logic [AW-1:0]    raddr,
	output logic [7:0]       rdata,
	output logic [CNT_W-1:0] count,
	output logic             ovf
);

	logic [7:0]       mem [LABEL_MAX];
	logic [7:0]       rdata_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;

	// New characters always land at the current fill position.
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[count_q[AW-1:0]] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (ctl.clear) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (ctl.wr) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (ctl.set_ovf) begin
				ovf_q <= 1'b1;
			end
		end
	end

	assign rdata = rdata_q;
	assign count = count_q;
	assign ovf   = ovf_q;

endmodule

// ----- src/dns_query_encoder.sv -----
// ----------------------------------------------------------------------------
// dns_query_encoder
// Byte-serial DNS query message builder driven by a small microcode program.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Word
//  item    | in        | item_valid/item_ready | item_t (action, name_char)
//  msg     | out       | msg_valid/msg_ready   | msg_t (out_byte, last, label_overflow)
//  apb     | in        | psel/penable/pready   | 32-bit registers at 0x0, 0x4, 0x8
//
// A character word other than a dot only stores its character and produces nothing.
// A start word runs 12 steps, a trailer word 5, a label flush (dot or end of name)
// count+1 steps, or none for an end word with an empty label; one step per cycle
// while msg is not stalled, each emitting one byte. item_ready returns in the cycle
// after the last step, so a word holds the input until its last byte is stepped.
// The step rate is set by the single output register and the one read port of the
// label memory. A stalled msg channel freezes the step counter. Reset clears the
// control state and registers; the label memory holds no reset value and needs none.
// ----------------------------------------------------------------------------
module dns_query_encoder
	import dqe_pkg::*;
#(
	parameter int LABEL_MAX = LABEL_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	output logic              msg_valid,
	input  logic              msg_ready,
	output msg_t              msg,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int CNT_W = $clog2(LABEL_MAX + 1);
	localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

	logic [15:0]      query_id_q;
	logic             rd_flag_q;
	logic [1:0]       qtype_q;

	logic             busy_q;
	logic [PC_W-1:0]  pc_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             msg_valid_q;
	msg_t             msg_q;

	ucode_t           uc;
	logic             accept;
	logic             adv;
	logic             step_last;
	logic [7:0]       step_byte;
	logic             is_dot;
	logic             room;
	lbuf_ctl_t        lctl;
	logic [7:0]       mem_rdata;
	logic [CNT_W-1:0] count;
	logic             ovf;
	reg_idx_t         reg_idx;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_id_q <= '0;
			rd_flag_q  <= 1'b0;
			qtype_q    <= 2'd1;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_QUERY_ID:   query_id_q <= pwdata[15:0];
				REG_RECURSION:  rd_flag_q  <= pwdata[0];
				REG_QUERY_TYPE: qtype_q    <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_QUERY_ID:   prdata = {16'd0, query_id_q};
			REG_RECURSION:  prdata = {31'd0, rd_flag_q};
			REG_QUERY_TYPE: prdata = {30'd0, qtype_q};
			default:        prdata = '0;
		endcase
	end

	// ---------------- sequencer ----------------
	assign item_ready = !busy_q;
	assign accept     = item_valid && item_ready;
	assign is_dot     = item.name_char == CHAR_DOT;
	assign room       = count < CNT_W'(LABEL_MAX);
	assign uc         = ucode_rom(pc_q);
	assign adv        = busy_q && (!msg_valid_q || msg_ready);

	always_comb begin
		case (uc.jmp)
			JMP_DONE:     step_last = 1'b1;
			JMP_IF_EMPTY: step_last = count == '0;
			JMP_LOOP:     step_last = rd_idx_q == count;
			default:      step_last = 1'b0;
		endcase
	end

	always_comb begin
		case (uc.src)
			SRC_ONE:   step_byte = 8'd1;
			SRC_ID_HI: step_byte = query_id_q[15:8];
			SRC_ID_LO: step_byte = query_id_q[7:0];
			SRC_RD:    step_byte = {7'd0, rd_flag_q};
			SRC_QTYPE: step_byte = {6'd0, qtype_q};
			SRC_COUNT: step_byte = 8'(count);
			SRC_MEM:   step_byte = mem_rdata;
			default:   step_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			pc_q     <= PC_HEADER;
			rd_idx_q <= '0;
		end else if (accept) begin
			rd_idx_q <= '0;
			case (action_t'(item.action))
				ACT_START: begin
					busy_q <= 1'b1;
					pc_q   <= PC_HEADER;
				end
				ACT_TRAILER: begin
					busy_q <= 1'b1;
					pc_q   <= PC_TRAILER;
				end
				ACT_END: begin
					busy_q <= count != '0;
					pc_q   <= PC_FLUSH;
				end
				default: begin
					busy_q <= is_dot;
					pc_q   <= PC_FLUSH;
				end
			endcase
		end else if (adv) begin
			if (uc.src == SRC_COUNT || uc.src == SRC_MEM) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (step_last) begin
				busy_q <= 1'b0;
			end else if (uc.jmp != JMP_LOOP) begin
				pc_q <= pc_q + PC_W'(1);
			end
		end
	end

	// The memory read for the next label byte is issued on the step before it
	// is emitted, so the registered read data lines up with the loop step.
	always_comb begin
		lctl.wr      = accept && action_t'(item.action) == ACT_CHAR && !is_dot && room;
		lctl.set_ovf = accept && action_t'(item.action) == ACT_CHAR && !is_dot && !room;
		lctl.clear   = adv && step_last;
		lctl.rd      = adv && (uc.src == SRC_COUNT || uc.src == SRC_MEM)
			&& rd_idx_q < CNT_W'(LABEL_MAX);
	end

	dqe_label_buf #(
		.LABEL_MAX(LABEL_MAX)
	) u_lbuf (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (lctl),
		.wdata (item.name_char),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (mem_rdata),
		.count (count),
		.ovf   (ovf)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_valid_q <= 1'b0;
		end else if (adv) begin
			msg_valid_q <= 1'b1;
		end else if (msg_ready) begin
			msg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			msg_q.out_byte       <= step_byte;
			msg_q.last           <= step_last;
			msg_q.label_overflow <= uc.use_ovf && ovf;
		end
	end

	assign msg_valid = msg_valid_q;
	assign msg       = msg_q;

	// ---------------- assertions ----------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(LABEL_MAX))
		else $error("label count beyond limit");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		adv && step_last |=> !busy_q && msg_valid && msg.last)
		else $error("last byte did not end the program");

	a_loop_index: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && uc.src == SRC_MEM |-> rd_idx_q != '0 && rd_idx_q <= count)
		else $error("label read index out of range");

endmodule
